[src/ccent_pkg.sv]
// shared types, widths and codes for the cluster centroid table
// no dependencies; imported by the divider, the top module, the checker and the testbench
package ccent_pkg;

    localparam int SUM_BITS       = 27;
    localparam int WEIGHT_BITS    = 16;
    localparam int BIRTH_BITS     = 32;
    localparam int RANGE_BITS     = 12;
    localparam int ID_BITS        = 6;
    localparam int CLUSTERS_DEF   = 64;
    localparam int COORD_BITS_DEF = 10;
    localparam int DIV_CNT_BITS   = $clog2(SUM_BITS);

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIVX,
        S_DIVY,
        S_DIST,
        S_CMP
    } t_state;

    typedef struct packed {
        logic        [BIRTH_BITS-1:0]  birth;
        logic signed [WEIGHT_BITS-1:0] weight;
        logic signed [SUM_BITS-1:0]    x_sum;
        logic signed [SUM_BITS-1:0]    y_sum;
        logic signed [SUM_BITS-1:0]    cent_x;
        logic signed [SUM_BITS-1:0]    cent_y;
        logic                          fresh;
    } t_entry;

    typedef struct packed {
        logic                          start;
        logic signed [SUM_BITS-1:0]    dividend;
        logic signed [WEIGHT_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                          done;
        logic signed [SUM_BITS-1:0]    quotient;
    } t_div_rsp;

endpackage

[src/ccent_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
module ccent_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/ccent_div.sv]
// shared restoring divider, signed dividend by positive divisor, one bit a cycle
// truncates toward zero; depends on ccent_pkg
module ccent_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccent_pkg::t_div_req i_req,
    output ccent_pkg::t_div_rsp o_rsp
);
    import ccent_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_neg;
    logic [WEIGHT_BITS-1:0]  r_rem;
    logic [SUM_BITS-1:0]     r_quo;
    logic [WEIGHT_BITS-1:0]  r_div;

    logic [WEIGHT_BITS:0]    shifted;
    logic [WEIGHT_BITS:0]    trial;
    logic                    fits;
    logic [SUM_BITS-1:0]     magnitude;

    assign shifted   = {r_rem, r_quo[SUM_BITS-1]};
    assign trial     = shifted - {1'b0, r_div};
    assign fits      = (shifted >= {1'b0, r_div});
    assign magnitude = i_req.dividend[SUM_BITS-1] ? SUM_BITS'(-i_req.dividend)
                                                  : SUM_BITS'(i_req.dividend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[SUM_BITS-1];
            r_quo <= magnitude;
            r_rem <= '0;
            r_div <= WEIGHT_BITS'(i_req.divisor);
        end else if (r_busy) begin
            r_rem <= fits ? trial[WEIGHT_BITS-1:0] : shifted[WEIGHT_BITS-1:0];
            r_quo <= {r_quo[SUM_BITS-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? $signed(-r_quo) : $signed(r_quo);

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_divisor_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (!i_req.divisor[WEIGHT_BITS-1] && (i_req.divisor != '0)))
        else $error("divider started with non-positive divisor");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");
`endif

endmodule

[src/cluster_centroid_table_top.sv]
// cluster centroid table: sequencer, entry store and distance check
// depends on ccent_pkg, ccent_ram and ccent_div
//
// from accepted start to result strobe, create, add and remove pass S_READ, S_EXEC;
// a query on a fresh or unusable centroid goes on through S_DIST and S_CMP, and a
// stale one first through S_DIVX and S_DIVY on the shared one-bit-a-cycle divider;
// one item at a time; reset: synchronous, active low; a clearing pass then writes
// every entry to zero with busy high; results are strobed, the receiver cannot stall
module cluster_centroid_table_top #(
    parameter int CLUSTERS   = ccent_pkg::CLUSTERS_DEF,
    parameter int COORD_BITS = ccent_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic [ccent_pkg::ID_BITS-1:0]       i_cluster_id,
    input  logic [COORD_BITS-1:0]               i_x,
    input  logic [COORD_BITS-1:0]               i_y,
    input  logic [ccent_pkg::RANGE_BITS-1:0]    i_range,
    input  logic [ccent_pkg::BIRTH_BITS-1:0]    i_birth_time,
    output logic                                o_valid,
    output logic                                o_in_range,
    output logic signed [ccent_pkg::SUM_BITS-1:0]    o_centroid_x,
    output logic signed [ccent_pkg::SUM_BITS-1:0]    o_centroid_y,
    output logic signed [ccent_pkg::WEIGHT_BITS-1:0] o_weight
);
    import ccent_pkg::*;

    localparam int AW        = $clog2(CLUSTERS);
    localparam int DIST_BITS = SUM_BITS + 1;

    // sequencer state and the clearing pass index
    t_state  r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;

    // request beat captured on accept
    t_req                  r_req;
    logic [AW-1:0]         r_idx;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [RANGE_BITS-1:0] r_range;
    logic [BIRTH_BITS-1:0] r_birth;

    // working copy of the addressed entry and the two distance terms
    t_entry               r_ent, n_ent;
    logic [DIST_BITS-1:0] r_dx, n_dx;
    logic [DIST_BITS-1:0] r_dy, n_dy;

    // result registers
    logic                          r_valid, n_valid;
    logic                          r_hit, n_hit;
    logic signed [SUM_BITS-1:0]    r_cx, n_cx;
    logic signed [SUM_BITS-1:0]    r_cy, n_cy;
    logic signed [WEIGHT_BITS-1:0] r_w, n_w;

    // store ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic accept;
    logic id_ok;
    logic signed [DIST_BITS-1:0] diff_x;
    logic signed [DIST_BITS-1:0] diff_y;
    logic [DIST_BITS:0]          manhattan;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    // ids beyond the table give an all-zero result and touch nothing
    assign id_ok  = (32'(i_cluster_id) < 32'(CLUSTERS));

    // point minus centroid, one bit wider than the centroid so it cannot wrap
    assign diff_x = $signed({1'b0, SUM_BITS'(r_x)})
                  - $signed({r_ent.cent_x[SUM_BITS-1], r_ent.cent_x});
    assign diff_y = $signed({1'b0, SUM_BITS'(r_y)})
                  - $signed({r_ent.cent_y[SUM_BITS-1], r_ent.cent_y});
    assign manhattan = (DIST_BITS + 1)'(r_dx) + (DIST_BITS + 1)'(r_dy);

    // entry store: the read address follows the request port, so the entry
    // addressed by an accepted beat is on the read data in the cycle after, in S_READ
    ccent_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CLUSTERS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(i_cluster_id)),
        .o_rdata (ram_rdata)
    );

    ccent_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= t_req'(i_req_type);
            r_idx   <= AW'(i_cluster_id);
            r_x     <= i_x;
            r_y     <= i_y;
            r_range <= i_range;
            r_birth <= i_birth_time;
        end
        r_ent <= n_ent;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_hit <= n_hit;
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        r_w   <= n_w;
    end

    always_comb begin
        t_entry upd;
        upd              = r_ent;
        n_state          = r_state;
        n_clr            = r_clr;
        n_ent            = r_ent;
        n_dx             = r_dx;
        n_dy             = r_dy;
        n_valid          = 1'b0;
        n_hit            = r_hit;
        n_cx             = r_cx;
        n_cy             = r_cy;
        n_w              = r_w;
        ram_we           = 1'b0;
        ram_waddr        = r_idx;
        ram_wdata        = r_ent;
        div_req.start    = 1'b0;
        div_req.dividend = r_ent.x_sum;
        div_req.divisor  = r_ent.weight;

        case (r_state)
            // one entry a cycle back to zero after reset
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(CLUSTERS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (id_ok) begin
                        n_state = S_READ;
                    end else begin
                        n_valid = 1'b1;
                        n_hit   = 1'b0;
                        n_cx    = '0;
                        n_cy    = '0;
                        n_w     = '0;
                    end
                end
            end
            S_READ: begin
                n_ent   = ram_rdata;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_req)
                    REQ_CREATE: begin
                        upd       = '0;
                        upd.birth = r_birth;
                        ram_we    = 1'b1;
                        ram_wdata = upd;
                        n_valid   = 1'b1;
                        n_hit     = 1'b0;
                        n_cx      = '0;
                        n_cy      = '0;
                        n_w       = '0;
                        n_state   = S_IDLE;
                    end
                    REQ_ADD, REQ_REMOVE: begin
                        // weight and sums wrap; the saved centroid is shown as is
                        if (r_req == REQ_ADD) begin
                            upd.weight = r_ent.weight + WEIGHT_BITS'(1);
                            upd.x_sum  = r_ent.x_sum + SUM_BITS'(r_x);
                            upd.y_sum  = r_ent.y_sum + SUM_BITS'(r_y);
                        end else begin
                            upd.weight = r_ent.weight - WEIGHT_BITS'(1);
                            upd.x_sum  = r_ent.x_sum - SUM_BITS'(r_x);
                            upd.y_sum  = r_ent.y_sum - SUM_BITS'(r_y);
                        end
                        upd.fresh = 1'b0;
                        ram_we    = 1'b1;
                        ram_wdata = upd;
                        n_valid   = 1'b1;
                        n_hit     = 1'b0;
                        n_cx      = r_ent.cent_x;
                        n_cy      = r_ent.cent_y;
                        n_w       = upd.weight;
                        n_state   = S_IDLE;
                    end
                    REQ_QUERY: begin
                        // recompute only a stale centroid with a positive weight
                        if (!r_ent.fresh && !r_ent.weight[WEIGHT_BITS-1]
                                && (r_ent.weight != '0)) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = r_ent.x_sum;
                            n_state          = S_DIVX;
                        end else begin
                            n_state = S_DIST;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            // x quotient in, same unit goes straight on to y
            S_DIVX: begin
                if (div_rsp.done) begin
                    n_ent.cent_x     = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = r_ent.y_sum;
                    n_state          = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_rsp.done) begin
                    n_ent.cent_y = div_rsp.quotient;
                    n_ent.fresh  = 1'b1;
                    n_state      = S_DIST;
                end
            end
            // manhattan terms registered before the sum and compare
            S_DIST: begin
                n_dx    = diff_x[DIST_BITS-1] ? DIST_BITS'(-diff_x) : DIST_BITS'(diff_x);
                n_dy    = diff_y[DIST_BITS-1] ? DIST_BITS'(-diff_y) : DIST_BITS'(diff_y);
                n_state = S_CMP;
            end
            S_CMP: begin
                ram_we    = 1'b1;
                ram_wdata = r_ent;
                n_valid   = 1'b1;
                n_hit     = (manhattan < (DIST_BITS + 1)'(r_range));
                n_cx      = r_ent.cent_x;
                n_cy      = r_ent.cent_y;
                n_w       = r_ent.weight;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid      = r_valid;
    assign o_in_range   = r_hit;
    assign o_centroid_x = r_cx;
    assign o_centroid_y = r_cy;
    assign o_weight     = r_w;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && id_ok) |=> busy)
        else $error("busy not raised after an accepted beat");
    a_fresh_needs_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_wdata.fresh) |->
            (!ram_wdata.weight[WEIGHT_BITS-1] && (ram_wdata.weight != '0)))
        else $error("fresh centroid stored with non-positive weight");
    a_quiet_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_valid && busy))
        else $error("result or idle seen during the clearing pass");
`endif

endmodule

[sim/ccent_checker.sv]
`timescale 1ns / 1ps
// result checker for the cluster centroid table: keeps its own copy of every entry,
// predicts each result from accepted requests and compares it field by field
// depends on ccent_pkg for request codes and field widths
module ccent_checker #(
    parameter int CLUSTERS   = ccent_pkg::CLUSTERS_DEF,
    parameter int COORD_BITS = ccent_pkg::COORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic                                     i_busy,
    input  logic [1:0]                               i_req_type,
    input  logic [ccent_pkg::ID_BITS-1:0]            i_cluster_id,
    input  logic [COORD_BITS-1:0]                    i_x,
    input  logic [COORD_BITS-1:0]                    i_y,
    input  logic [ccent_pkg::RANGE_BITS-1:0]         i_range,
    input  logic [ccent_pkg::BIRTH_BITS-1:0]         i_birth_time,
    input  logic                                     i_valid,
    input  logic                                     i_in_range,
    input  logic signed [ccent_pkg::SUM_BITS-1:0]    i_centroid_x,
    input  logic signed [ccent_pkg::SUM_BITS-1:0]    i_centroid_y,
    input  logic signed [ccent_pkg::WEIGHT_BITS-1:0] i_weight,
    output int                                       o_pending,
    output int                                       o_fails
);

    localparam int SB = ccent_pkg::SUM_BITS;
    localparam int WB = ccent_pkg::WEIGHT_BITS;
    localparam int MAX_LINES = 100;

    typedef struct packed {
        ccent_pkg::t_req               req;
        logic [ccent_pkg::ID_BITS-1:0] id;
        logic                          hit;
        logic signed [SB-1:0]          cx;
        logic signed [SB-1:0]          cy;
        logic signed [WB-1:0]          wt;
    } t_centroid_result;

    // shadow of the entry table
    logic signed [WB-1:0]                    weight_tab [CLUSTERS];
    logic signed [SB-1:0]                    xsum_tab   [CLUSTERS];
    logic signed [SB-1:0]                    ysum_tab   [CLUSTERS];
    logic signed [SB-1:0]                    cx_tab     [CLUSTERS];
    logic signed [SB-1:0]                    cy_tab     [CLUSTERS];
    logic                                    fresh_tab  [CLUSTERS];
    logic [ccent_pkg::BIRTH_BITS-1:0]        birth_tab  [CLUSTERS];

    t_centroid_result centroid_results_due [$];

    task automatic report_mismatch(input string what, input t_centroid_result due,
                                   input longint got, input longint want);
        o_fails++;
        if (o_fails <= MAX_LINES)
            $display("%0t mismatch %s: req %0d entry %0d got %0d want %0d",
                     $realtime, what, due.req, due.id, got, want);
    endtask

    // applies one request to the shadow table and works out its result
    task automatic update_cluster_table(input ccent_pkg::t_req req, input int unsigned id,
                                        input logic [COORD_BITS-1:0] px,
                                        input logic [COORD_BITS-1:0] py,
                                        input logic [ccent_pkg::RANGE_BITS-1:0] lim,
                                        input logic [ccent_pkg::BIRTH_BITS-1:0] born,
                                        output t_centroid_result res);
        longint q;
        longint dx;
        longint dy;
        res     = '0;
        res.req = req;
        res.id  = id[ccent_pkg::ID_BITS-1:0];
        if (id < CLUSTERS) begin
            case (req)
                ccent_pkg::REQ_CREATE: begin
                    birth_tab[id]  = born;
                    weight_tab[id] = '0;
                    xsum_tab[id]   = '0;
                    ysum_tab[id]   = '0;
                    cx_tab[id]     = '0;
                    cy_tab[id]     = '0;
                    fresh_tab[id]  = 1'b0;
                end
                ccent_pkg::REQ_ADD: begin
                    weight_tab[id] = weight_tab[id] + 1'b1;
                    xsum_tab[id]   = xsum_tab[id] + px;
                    ysum_tab[id]   = ysum_tab[id] + py;
                    fresh_tab[id]  = 1'b0;
                end
                ccent_pkg::REQ_REMOVE: begin
                    weight_tab[id] = weight_tab[id] - 1'b1;
                    xsum_tab[id]   = xsum_tab[id] - px;
                    ysum_tab[id]   = ysum_tab[id] - py;
                    fresh_tab[id]  = 1'b0;
                end
                default: begin
                    // recompute only a stale centroid of a positive weight
                    if (!fresh_tab[id] && weight_tab[id] > 0) begin
                        q = longint'(xsum_tab[id]) / longint'(weight_tab[id]);
                        cx_tab[id] = q[SB-1:0];
                        q = longint'(ysum_tab[id]) / longint'(weight_tab[id]);
                        cy_tab[id] = q[SB-1:0];
                        fresh_tab[id] = 1'b1;
                    end
                    dx = longint'(px) - longint'(cx_tab[id]);
                    dy = longint'(py) - longint'(cy_tab[id]);
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    res.hit = (dx + dy) < longint'(lim);
                end
            endcase
            res.cx = cx_tab[id];
            res.cy = cy_tab[id];
            res.wt = weight_tab[id];
        end
    endtask

    always @(posedge i_clk) begin
        t_centroid_result due;
        t_centroid_result res;
        if (!i_rst_n) begin
            for (int i = 0; i < CLUSTERS; i++) begin
                weight_tab[i] = '0;
                xsum_tab[i]   = '0;
                ysum_tab[i]   = '0;
                cx_tab[i]     = '0;
                cy_tab[i]     = '0;
                fresh_tab[i]  = 1'b0;
                birth_tab[i]  = '0;
            end
            centroid_results_due.delete();
            o_fails = 0;
        end else begin
            if (i_valid) begin
                if (centroid_results_due.size() == 0) begin
                    due = '0;
                    report_mismatch("unexpected result", due, i_weight, 0);
                end else begin
                    due = centroid_results_due.pop_front();
                    if (i_in_range !== due.hit)
                        report_mismatch("in_range", due, i_in_range, due.hit);
                    if (i_centroid_x !== due.cx)
                        report_mismatch("centroid_x", due, i_centroid_x, due.cx);
                    if (i_centroid_y !== due.cy)
                        report_mismatch("centroid_y", due, i_centroid_y, due.cy);
                    if (i_weight !== due.wt)
                        report_mismatch("weight", due, i_weight, due.wt);
                end
            end
            if (i_start && !i_busy) begin
                update_cluster_table(ccent_pkg::t_req'(i_req_type), 32'(i_cluster_id),
                                     i_x, i_y, i_range, i_birth_time, res);
                centroid_results_due.push_back(res);
            end
        end
        o_pending = centroid_results_due.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// top of the cluster centroid table testbench: clock, reset, request stimulus and verdict
// depends on ccent_pkg, cluster_centroid_table_top and ccent_checker
module tb;

    import ccent_pkg::*;

    localparam int CLUSTERS    = CLUSTERS_DEF;
    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int TOTAL_BEATS = 1950;
    localparam int SEGMENTS    = 6;
    // a stale query is the longest item, so the drain leaves a margin on that
    localparam int DRAIN_CYCLES = 80;
    // quiet cycles allowed: clearing pass, longest query and a long sender gap, many times
    localparam int QUIET_LIMIT  = 2000;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    start        = 1'b0;
    logic                    busy;
    logic [1:0]              i_req_type   = '0;
    logic [ID_BITS-1:0]      i_cluster_id = '0;
    logic [COORD_BITS-1:0]   i_x          = '0;
    logic [COORD_BITS-1:0]   i_y          = '0;
    logic [RANGE_BITS-1:0]   i_range      = '0;
    logic [BIRTH_BITS-1:0]   i_birth_time = '0;
    logic                    o_valid;
    logic                    o_in_range;
    logic signed [SUM_BITS-1:0]    o_centroid_x;
    logic signed [SUM_BITS-1:0]    o_centroid_y;
    logic signed [WEIGHT_BITS-1:0] o_weight;

    int          n_pending;
    int          n_fails;
    int unsigned beats_sent = 0;
    int unsigned idle_pct   = 0;
    int unsigned quiet_cycles = 0;

    cluster_centroid_table_top #(
        .CLUSTERS   (CLUSTERS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_cluster_id (i_cluster_id),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_range      (i_range),
        .i_birth_time (i_birth_time),
        .o_valid      (o_valid),
        .o_in_range   (o_in_range),
        .o_centroid_x (o_centroid_x),
        .o_centroid_y (o_centroid_y),
        .o_weight     (o_weight)
    );

    ccent_checker #(
        .CLUSTERS   (CLUSTERS),
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req_type   (i_req_type),
        .i_cluster_id (i_cluster_id),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_range      (i_range),
        .i_birth_time (i_birth_time),
        .i_valid      (o_valid),
        .i_in_range   (o_in_range),
        .i_centroid_x (o_centroid_x),
        .i_centroid_y (o_centroid_y),
        .i_weight     (o_weight),
        .o_pending    (n_pending),
        .o_fails      (n_fails)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: ends the run when neither a request nor a result moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("[cluster_centroid_table_top] ERROR");
                $finish;
            end
        end
    end

    // one request beat, called at a falling edge; returns at the falling edge after
    // the beat has been taken, with an optional sender gap behind it
    task automatic put_beat(input t_req req, input int unsigned id,
                            input int unsigned px, input int unsigned py,
                            input int unsigned lim, input logic [BIRTH_BITS-1:0] born);
        i_req_type   <= req;
        i_cluster_id <= id[ID_BITS-1:0];
        i_x          <= px[COORD_BITS-1:0];
        i_y          <= py[COORD_BITS-1:0];
        i_range      <= lim[RANGE_BITS-1:0];
        i_birth_time <= born;
        start        <= 1'b1;
        // busy only moves on a rising edge, so its value here holds at the next one
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        beats_sent++;
        // sender gap: start stays high when no gap is drawn
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // hold the sender off until every outstanding result is back, then let the block settle
    task automatic wait_drained();
        start <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // coordinate scattered around a centre, clamped to the field so edges come up often
    function automatic int unsigned near_coord(input int unsigned c, input int unsigned spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 0) v = 0;
        if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
        return v;
    endfunction

    task automatic put_query(input int unsigned id, input int unsigned cx,
                             input int unsigned cy, input int unsigned spread);
        int unsigned lim;
        // mostly ranges close to the expected distance, so both outcomes turn up
        if ($urandom_range(0, 3) != 0) lim = $urandom_range(0, 3 * spread + 2);
        else lim = $urandom_range(0, (1 << RANGE_BITS) - 1);
        put_beat(REQ_QUERY, id, near_coord(cx, spread), near_coord(cy, spread), lim, $urandom);
    endtask

    // corners and special cases, each step noted
    task automatic run_directed();
        // untouched entry: zero weight, stale zero centroid
        put_beat(REQ_QUERY,  5, 0, 0, 1, 0);
        put_beat(REQ_CREATE, 63, 1023, 1023, 4095, 32'hFFFF_FFFF);
        put_beat(REQ_ADD,    63, 1023, 1023, 0, 0);
        // distance zero against range zero misses, against one hits
        put_beat(REQ_QUERY,  63, 1023, 1023, 0, 0);
        put_beat(REQ_QUERY,  63, 1023, 1023, 1, 0);
        put_beat(REQ_ADD,    63, 0, 0, 0, 0);
        put_beat(REQ_QUERY,  63, 0, 1023, 4095, 0);
        // back to weight zero: saved centroid kept, stays stale
        put_beat(REQ_REMOVE, 63, 1023, 1023, 0, 0);
        put_beat(REQ_REMOVE, 63, 0, 0, 0, 0);
        put_beat(REQ_QUERY,  63, 512, 512, 4095, 0);
        // negative weight and a negative x sum
        put_beat(REQ_REMOVE, 63, 1023, 0, 0, 0);
        put_beat(REQ_QUERY,  63, 0, 0, 2048, 0);
        // positive weight over negative sums: quotient truncates toward zero
        put_beat(REQ_CREATE, 0, 0, 0, 0, 32'h0000_0000);
        put_beat(REQ_ADD,    0, 0, 0, 0, 0);
        put_beat(REQ_ADD,    0, 0, 0, 0, 0);
        put_beat(REQ_ADD,    0, 0, 0, 0, 0);
        put_beat(REQ_REMOVE, 0, 1023, 1, 0, 0);
        put_beat(REQ_QUERY,  0, 0, 0, 4095, 0);
        put_beat(REQ_QUERY,  0, 1023, 1023, 2047, 0);
        // create over a used entry clears it
        put_beat(REQ_CREATE, 0, 1023, 1023, 4095, 32'h8000_0001);
        put_beat(REQ_QUERY,  0, 0, 0, 0, 0);
    endtask

    // mostly well-formed cluster histories with random content, some raw noise
    task automatic run_cluster_bursts(input int unsigned upto);
        int unsigned id;
        int unsigned cx;
        int unsigned cy;
        int unsigned spread;
        int unsigned n_pts;
        int unsigned pick;
        while (beats_sent < upto) begin
            if ($urandom_range(0, 9) == 0) begin
                put_beat(t_req'($urandom_range(0, 3)), $urandom_range(0, CLUSTERS - 1),
                         $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 4095), $urandom);
            end else begin
                // a few entries get revisited often so their state builds up
                id = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                          : $urandom_range(0, CLUSTERS - 1);
                cx = $urandom_range(0, 1023);
                cy = $urandom_range(0, 1023);
                spread = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(16, 200);
                if ($urandom_range(0, 9) < 7)
                    put_beat(REQ_CREATE, id, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 4095), $urandom);
                n_pts = $urandom_range(1, 10);
                for (int k = 0; k < n_pts; k++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        put_beat(REQ_ADD, id, near_coord(cx, spread), near_coord(cy, spread),
                                 $urandom_range(0, 4095), $urandom);
                    else if (pick < 8)
                        put_query(id, cx, cy, spread);
                    else
                        put_beat(REQ_REMOVE, id, near_coord(cx, spread),
                                 near_coord(cy, spread), $urandom_range(0, 4095), $urandom);
                end
                repeat ($urandom_range(1, 3)) put_query(id, cx, cy, spread);
            end
        end
    endtask

    initial begin
        int unsigned seg_pct [3];
        seg_pct = '{0, 71, 36};
        // reset held from the start, released on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        // sender pauses until every result is back before the random part
        wait_drained();

        // random part in segments: no gaps, heavy sender gaps, lighter sender gaps
        for (int s = 0; s < SEGMENTS; s++) begin
            idle_pct = seg_pct[s % 3];
            run_cluster_bursts(beats_sent + (TOTAL_BEATS - beats_sent) / (SEGMENTS - s));
            if (s % 2 == 1) wait_drained();
        end

        wait_drained();
        if (n_fails == 0) begin
            $display("[cluster_centroid_table_top] OK");
        end else begin
            $display("[cluster_centroid_table_top] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
src/ccent_pkg.sv
src/ccent_ram.sv
src/ccent_div.sv
src/cluster_centroid_table_top.sv
sim/ccent_checker.sv
sim/tb.sv
